/* design/crsf_pkg.sv */
// Shared constants, codes and types for the CRSF RC-channels frame receiver.
// Used by crsf_ctrl, crsf_dp and crsf_rc_frame_receiver. No dependencies.
package crsf_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN     = 24;
	localparam int unsigned PAYLOAD_BYTES = 22;
	localparam int unsigned NUM_CHANNELS  = 16;
	localparam int unsigned CHAN_W        = 11;
	localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;

	localparam logic [7:0] FRAME_LEN_BYTE = 8'(FRAME_LEN);
	localparam logic [7:0] CRC_POLY       = 8'hD5;
	localparam logic [7:0] SYNC_RESET     = 8'hC8;

	// Body byte counter: 0..FRAME_LEN-1
	localparam logic [4:0] BODY_LAST_CNT = 5'(FRAME_LEN - 1);
	localparam logic [3:0] CH_LAST       = 4'(NUM_CHANNELS - 1);

	// Result status codes
	localparam logic [1:0] STATUS_CHAN    = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
	localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       sync_we;
		logic       crc_clear;
		logic       crc_upd;
		logic       pay_in;
		logic       pay_next;
		logic       out_load;
		logic       out_chan;
		logic [1:0] out_status;
		logic [3:0] out_index;
		logic       out_last;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sync_hit;
		logic len_ok;
		logic crc_ok;
		logic out_free;
	} dp_sts_t;

	// One CRC-8 byte update, MSB first, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/crsf_dp.sv */
// Datapath of the CRSF frame receiver: sync register, running CRC, payload
// shift line and the result output register. Depends on crsf_pkg.
module crsf_dp
	import crsf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic [7:0]           cfg_wdata,
	input  logic [7:0]           rx_byte,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [1:0]           status,
	output logic [3:0]           channel_index,
	output logic [CHAN_W-1:0]    channel_value,
	output logic                 last
);

	logic [7:0]           sync_q;
	logic [7:0]           crc_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [3:0]           index_q;
	logic [CHAN_W-1:0]    value_q;
	logic                 last_q;

	// Status back to the controller
	assign sts.sync_hit = (rx_byte == sync_q);
	assign sts.len_ok   = (rx_byte == FRAME_LEN_BYTE);
	assign sts.crc_ok   = (rx_byte == crc_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	// Sync address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cmd.sync_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// Running CRC over type and payload bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (cmd.crc_clear) begin
			crc_q <= '0;
		end else if (cmd.crc_upd) begin
			crc_q <= crc8_step(crc_q, rx_byte);
		end
	end

	// Payload shift line: bytes enter at the top, channels leave at the bottom
	always_ff @(posedge clk) begin
		if (cmd.pay_in) begin
			pay_q <= {rx_byte, pay_q[PAYLOAD_W-1:8]};
		end else if (cmd.pay_next) begin
			pay_q <= pay_q >> CHAN_W;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			index_q  <= cmd.out_index;
			value_q  <= cmd.out_chan ? pay_q[CHAN_W-1:0] : '0;
			last_q   <= cmd.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign last          = last_q;

endmodule

/* design/crsf_ctrl.sv */
// Controller of the CRSF frame receiver: frame phase, body byte count and
// channel emit sequencing. Depends on crsf_pkg.
module crsf_ctrl
	import crsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    cfg_we,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_HUNT = 2'd0;
	localparam logic [1:0] ST_LEN  = 2'd1;
	localparam logic [1:0] ST_BODY = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [3:0] ch_q, ch_d;
	logic       in_acc;

	// No input while emitting channels or while the output slot stays full
	assign in_stall = (state_q == ST_EMIT) || !sts.out_free;
	assign in_acc   = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		ch_d           = ch_q;
		cmd            = '0;
		cmd.sync_we    = cfg_we;
		cmd.out_status = STATUS_CHAN;
		unique case (state_q)
			ST_HUNT: begin
				if (in_acc && sts.sync_hit) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (in_acc) begin
					if (sts.len_ok) begin
						state_d       = ST_BODY;
						cnt_d         = '0;
						cmd.crc_clear = 1'b1;
					end else begin
						state_d        = ST_HUNT;
						cmd.out_load   = 1'b1;
						cmd.out_status = STATUS_BAD_LEN;
						cmd.out_last   = 1'b1;
					end
				end
			end
			ST_BODY: begin
				if (in_acc) begin
					if (cnt_q != BODY_LAST_CNT) begin
						// type byte and payload feed the CRC; payload also the store
						cmd.crc_upd = 1'b1;
						cmd.pay_in  = (cnt_q != '0);
						cnt_d       = cnt_q + 5'd1;
					end else begin
						cnt_d = '0;
						if (sts.crc_ok) begin
							state_d = ST_EMIT;
							ch_d    = '0;
						end else begin
							state_d        = ST_HUNT;
							cmd.out_load   = 1'b1;
							cmd.out_status = STATUS_BAD_CRC;
							cmd.out_last   = 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				// one channel item per free output slot
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_chan  = 1'b1;
					cmd.out_index = ch_q;
					cmd.out_last  = (ch_q == CH_LAST);
					cmd.pay_next  = 1'b1;
					if (ch_q == CH_LAST) begin
						state_d = ST_HUNT;
					end else begin
						ch_d = ch_q + 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			cnt_q   <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ch_q    <= ch_d;
		end
	end

endmodule

/* design/crsf_rc_frame_receiver.sv */
// Top level of the CRSF RC-channels frame receiver.
// Instantiates crsf_ctrl and crsf_dp; depends on crsf_pkg.

// Takes one received byte per cycle while hunting and collecting a frame,
// unless in_stall is high; every byte that completes nothing is absorbed. A
// frame is sync byte (sync_address, reset 0xC8), length byte 24, type byte,
// 22 payload bytes and a CRC-8 (poly 0xD5, init 0) over type and payload. A
// wrong length gives one bad-length item, a CRC mismatch one bad-CRC item; a
// good frame gives 16 channel items, one per cycle of free output slot, and
// in_stall stays high while they are emitted since the channels are shifted
// out of the payload register one at a time. A result waits in one output
// register; in_stall is also high while it is full and out_stall is high.
module crsf_rc_frame_receiver
	import crsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [3:0]        channel_index,
	output logic [CHAN_W-1:0] channel_value,
	output logic              last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Frame controller
	crsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.cmd      (cmd)
	);

	// CRC, payload and output datapath
	crsf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wdata     (cfg_wdata),
		.rx_byte       (rx_byte),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

endmodule

/* sim/tb.sv */
// Testbench for crsf_rc_frame_receiver: a frame predictor in a small scoreboard
// class checks every output item, while tasks drive bytes and sync settings.
// Depends on crsf_pkg and crsf_rc_frame_receiver.
module tb;
	import crsf_pkg::*;

	localparam int WIRE_LEN = FRAME_LEN + 2;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {HUNT, WANT_LEN, IN_BODY} rx_phase_t;
	typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [3:0]        index;
		logic [CHAN_W-1:0] value;
		logic              last;
	} rc_result_t;

	// Frame predictor plus the queue of results still owed by the block
	class rc_frame_checker;
		logic [7:0]  sync_addr;
		rx_phase_t   phase;
		int          body_count;
		logic [7:0]  crc;
		logic [7:0]  payload_bytes [PAYLOAD_BYTES];
		rc_result_t  results_owed [$];
		int          errors;
		int          good_frames;
		int          bad_lens;
		int          bad_crcs;

		function new();
			sync_addr = SYNC_RESET;
			phase = HUNT;
			body_count = 0;
			crc = 8'h00;
			errors = 0;
			good_frames = 0;
			bad_lens = 0;
			bad_crcs = 0;
		endfunction

		// CRC-8, MSB first, no reflection
		static function logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
			logic [7:0] r;
			r = c ^ b;
			for (int i = 0; i < 8; i++) begin
				r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
			end
			return r;
		endfunction

		function void owe(logic [1:0] st, logic [3:0] idx, logic [CHAN_W-1:0] val,
				logic lst);
			rc_result_t r;
			r.status = st;
			r.index = idx;
			r.value = val;
			r.last = lst;
			results_owed.push_back(r);
		endfunction

		// One accepted byte
		function void take_byte(logic [7:0] b);
			logic [PAYLOAD_W-1:0] bits;
			case (phase)
				WANT_LEN: begin
					if (b == FRAME_LEN_BYTE) begin
						phase = IN_BODY;
						body_count = 0;
						crc = 8'h00;
					end else begin
						phase = HUNT;
						owe(STATUS_BAD_LEN, 4'd0, '0, 1'b1);
					end
				end
				IN_BODY: begin
					if (body_count < FRAME_LEN - 1) begin
						crc = crc_byte(crc, b);
						if (body_count >= 1) payload_bytes[body_count - 1] = b;
						body_count++;
					end else begin
						phase = HUNT;
						body_count = 0;
						if (b != crc) begin
							owe(STATUS_BAD_CRC, 4'd0, '0, 1'b1);
						end else begin
							// channels packed LSB first across the payload
							for (int i = 0; i < PAYLOAD_BYTES; i++) bits[i*8 +: 8] = payload_bytes[i];
							for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
								owe(STATUS_CHAN, 4'(ch), bits[ch*CHAN_W +: CHAN_W],
									ch == NUM_CHANNELS - 1);
							end
						end
					end
				end
				default: begin
					phase = (b == sync_addr) ? WANT_LEN : HUNT;
				end
			endcase
		endfunction

		function void compare_field(string what, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		// One accepted output item against the oldest owed result
		function void check_result(rc_result_t got);
			rc_result_t want;
			if (results_owed.size() == 0) begin
				$display("%0t: unexpected item, expected none actual status %0d index %0d value %0d",
					$time, got.status, got.index, got.value);
				errors++;
				return;
			end
			want = results_owed.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("channel_index", want.index, got.index);
			compare_field("channel_value", want.value, got.value);
			compare_field("last", want.last, got.last);
			if (want.last && want.status == STATUS_CHAN) good_frames++;
			if (want.status == STATUS_BAD_LEN) bad_lens++;
			if (want.status == STATUS_BAD_CRC) bad_crcs++;
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [7:0]        cfg_wdata = 8'h00;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [3:0]        channel_index;
	logic [CHAN_W-1:0] channel_value;
	logic              last;

	rc_frame_checker sb = new();
	bit steady = 1'b0;
	int stall_left = 0;
	int bytes_sent = 0;
	int settings = 1;
	int cycles = 0;

	crsf_rc_frame_receiver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idle runs, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 40))
			: int'($urandom_range(1, 3));
	endfunction

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.results_owed.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Output back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!steady && $urandom_range(0, 3) == 0) stall_left <= idle_len();
		end
	end

	// Handshake monitor: accepted bytes feed the predictor, accepted items are checked
	always @(posedge clk) begin : monitor
		rc_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) sb.take_byte(rx_byte);
			if (out_valid && !out_stall) begin
				got.status = status;
				got.index = channel_index;
				got.value = channel_value;
				got.last = last;
				sb.check_result(got);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? idle_len() : 0);
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pauses until every owed result is back, then lets the block settle
	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.results_owed.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.sync_addr = v;
		settings++;
	endtask

	// Sync, length, type, payload, CRC; keep < WIRE_LEN cuts the frame short
	task automatic send_frame(input fill_t fill, input bit corrupt, input int keep);
		logic [7:0] wire_bytes [WIRE_LEN];
		logic [7:0] c;
		wire_bytes[0] = sb.sync_addr;
		wire_bytes[1] = FRAME_LEN_BYTE;
		c = 8'h00;
		for (int i = 2; i < WIRE_LEN - 1; i++) begin
			case (fill)
				FILL_ZERO: wire_bytes[i] = 8'h00;
				FILL_ONES: wire_bytes[i] = 8'hFF;
				default:   wire_bytes[i] = 8'($urandom_range(0, 255));
			endcase
			c = rc_frame_checker::crc_byte(c, wire_bytes[i]);
		end
		wire_bytes[WIRE_LEN - 1] = corrupt ? (c ^ 8'($urandom_range(1, 255))) : c;
		for (int i = 0; i < keep; i++) send_byte(wire_bytes[i]);
	endtask

	task automatic send_bad_len();
		logic [7:0] n;
		n = ($urandom_range(0, 3) == 0) ? sb.sync_addr : 8'($urandom_range(0, 255));
		if (n == FRAME_LEN_BYTE) n = n + 8'd1;
		send_byte(sb.sync_addr);
		send_byte(n);
	endtask

	initial begin : stimulus
		logic [7:0] sync_plan [5];
		int start;
		int r;
		sync_plan[0] = 8'h00;
		sync_plan[1] = 8'hFF;
		sync_plan[2] = FRAME_LEN_BYTE;
		sync_plan[3] = 8'($urandom_range(0, 255));
		sync_plan[4] = SYNC_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: noise, bad lengths at the edges, sync as length, all-ones and bad CRC
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_RESET);
		send_byte(8'h00);
		send_byte(SYNC_RESET);
		send_byte(8'hFF);
		send_byte(SYNC_RESET);
		send_byte(FRAME_LEN_BYTE - 8'd1);
		send_byte(SYNC_RESET);
		send_byte(FRAME_LEN_BYTE + 8'd1);
		// second sync is a bad length, the following 24 is only noise
		send_byte(SYNC_RESET);
		send_byte(SYNC_RESET);
		send_byte(FRAME_LEN_BYTE);
		send_frame(FILL_ONES, 1'b0, WIRE_LEN);
		send_frame(FILL_ZERO, 1'b1, WIRE_LEN);

		// Random: mostly well-formed frames, with bad CRCs, bad lengths, noise, cut frames
		for (int p = 0; p < 5; p++) begin
			wait_idle(8);
			write_sync(sync_plan[p]);
			steady = (p == 2);
			start = bytes_sent;
			while (bytes_sent - start < 10) begin
				r = $urandom_range(0, 19);
				if (r < 10) begin
					r = $urandom_range(0, 7);
					send_frame((r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM,
						1'b0, WIRE_LEN);
				end else if (r < 13) begin
					send_frame(FILL_RANDOM, 1'b1, WIRE_LEN);
				end else if (r < 16) begin
					send_bad_len();
				end else if (r < 18) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end else begin
					send_frame(FILL_RANDOM, 1'b0, $urandom_range(3, 20));
				end
			end
		end
		steady = 1'b0;

		wait_idle(20);
		if (sb.results_owed.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.results_owed.size());
			sb.errors++;
		end
		$display("Run covered %0d bytes over %0d sync settings: %0d good frames,",
			bytes_sent, settings, sb.good_frames);
		$display("  %0d bad-length and %0d bad-CRC items, %0d mismatches",
			sb.bad_lens, sb.bad_crcs, sb.errors);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
